// ===== rtl/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg
// shared types, widths and constants of the windowed timing statistics block
// ----------------------------------------------------------------------------
package wts_pkg;

	localparam int TIME_W       = 64;
	localparam int WORD_W       = 32;
	localparam int LOAD_W       = 15;
	localparam int DIV_W        = 80;
	localparam int NARROW_PAD   = DIV_W - TIME_W;
	localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
	localparam int PROD25_W     = TIME_W + 5;
	localparam int LOAD_SHIFT   = 10;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WIDE   = DIV_CNT_W'(DIV_W);
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NARROW = DIV_CNT_W'(TIME_W);

	localparam logic [LOAD_W-1:0] LOAD_FULL_Q8       = 15'd25600;
	localparam logic [WORD_W-1:0] INTERVAL_RESET_US  = 32'd1000000;
	localparam logic [WORD_W-1:0] WORD_MAX           = '1;

	typedef struct packed {
		logic start;
		logic wide;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [WORD_W-1:0] sat32(input logic [DIV_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (v[DIV_W-1:WORD_W] != '0) begin
			r = WORD_MAX;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/wts_div.sv =====
// ----------------------------------------------------------------------------
// wts_div
// restoring divider, one quotient bit per cycle, 80 or 64 bit dividend
// ----------------------------------------------------------------------------
module wts_div import wts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_cmd_t             cmd,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [TIME_W-1:0]    divisor,
	output div_stat_t            stat,
	output logic [DIV_W-1:0]     quotient
);

	logic [DIV_W-1:0]     dvd_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TIME_W:0] shifted;
	logic [TIME_W:0] diff;
	logic            ge;

	always_comb begin
		shifted = {rem_q, dvd_q[DIV_W-1]};
		diff    = shifted - {1'b0, dsr_q};
		ge      = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.wide ? DIV_STEPS_WIDE : DIV_STEPS_NARROW;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			if (cmd.wide) begin
				dvd_q <= dividend;
			end else begin
				dvd_q <= {dividend[TIME_W-1:0], {NARROW_PAD{1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider busy with zero step count");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("divider done without work");
`endif

endmodule

// ===== rtl/windowed_timing_statistics.sv =====
// ----------------------------------------------------------------------------
// windowed_timing_statistics
// loop and detection timing monitor with windowed min, max and average report
// ----------------------------------------------------------------------------
// One request at a time. A detection batch (tuser 1) holds the input off in the
// cycle after acceptance, a loop event (tuser 0) that does not close the window
// through S_DUR, S_ACC and S_CHK. A loop event that closes the window runs load
// share, loop average and detection average one after another on one shared
// restoring divider at one quotient bit per cycle (80 steps, then 64 and 64); the
// report is offered and the input is ready again together once the output
// register is free. The report sits in its own output register, so requests keep
// flowing while it waits; a further window close holds in its last step until the
// previous report has been taken. The interval register may be written at any
// time the block is idle and takes effect at the next loop event.
module windowed_timing_statistics import wts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,     // window interval in us
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic         s_axis_tuser,  // op
	// start_time_us, end_time_us, batch_sum_us, batch_samples, batch_min_us, batch_max_us
	input  logic [287:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// window_length_us, load_percent_q8, loop_count, loop_mean_us, loop_peak_us,
	// detect_count, detect_total_us, detect_average_us, detect_floor_us,
	// detect_peak_us, one zero pad bit
	output logic [335:0] m_axis_tdata
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DET    = 9'b000000010,
		S_DUR    = 9'b000000100,
		S_ACC    = 9'b000001000,
		S_CHK    = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_DSTART = 9'b001000000,
		S_DWAIT  = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		JOB_LOAD = 2'd0,
		JOB_LAVG = 2'd1,
		JOB_DAVG = 2'd2
	} div_job_t;

	state_t   state_q;
	div_job_t job_q;

	logic [WORD_W-1:0] interval_q;

	// request fields
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] end_q;
	logic [TIME_W-1:0] bsum_q;
	logic [WORD_W-1:0] bsamples_q;
	logic [WORD_W-1:0] bmin_q;
	logic [WORD_W-1:0] bmax_q;

	// accumulators
	logic [TIME_W-1:0] open_q;
	logic [TIME_W-1:0] loop_total_q;
	logic [WORD_W-1:0] loop_peak_q;
	logic [WORD_W-1:0] loop_tally_q;
	logic [TIME_W-1:0] det_total_q;
	logic [WORD_W-1:0] det_floor_q;
	logic [WORD_W-1:0] det_peak_q;
	logic [WORD_W-1:0] det_tally_q;

	// working values
	logic [WORD_W-1:0]   dur_q;
	logic [TIME_W:0]     elapsed_q;
	logic [TIME_W-1:0]   snap_total_q;
	logic [PROD25_W-1:0] prod25_q;
	logic                load_full_q;

	// report
	logic [WORD_W-1:0] res_win_q;
	logic [LOAD_W-1:0] res_load_q;
	logic [WORD_W-1:0] res_lcount_q;
	logic [WORD_W-1:0] res_lavg_q;
	logic [WORD_W-1:0] res_lpeak_q;
	logic [WORD_W-1:0] res_dcount_q;
	logic [TIME_W-1:0] res_dtotal_q;
	logic [WORD_W-1:0] res_davg_q;
	logic [WORD_W-1:0] res_dfloor_q;
	logic [WORD_W-1:0] res_dpeak_q;

	// output register
	logic [335:0] report_q;
	logic         report_valid_q;

	logic [TIME_W:0]   span;
	logic              close;
	logic              load_report;
	logic [DIV_W-1:0]  div_dividend;
	logic [TIME_W-1:0] div_divisor;
	logic [DIV_W-1:0]  div_quot;
	div_cmd_t          div_cmd;
	div_stat_t         div_stat;

	assign span  = {1'b0, end_q} - {1'b0, start_q};
	assign close = (open_q != '0) && !elapsed_q[TIME_W] && (elapsed_q != '0) &&
		(elapsed_q[TIME_W-1:0] >= {{(TIME_W-WORD_W){1'b0}}, interval_q});
	assign load_report = (state_q == S_OUT) && (!report_valid_q || m_axis_tready);

	always_comb begin
		div_cmd.start = (state_q == S_DSTART);
		div_cmd.wide  = (job_q == JOB_LOAD);
		case (job_q)
			JOB_LOAD: begin
				div_dividend = DIV_W'({prod25_q, {LOAD_SHIFT{1'b0}}});
				div_divisor  = elapsed_q[TIME_W-1:0];
			end
			JOB_LAVG: begin
				div_dividend = DIV_W'(snap_total_q);
				div_divisor  = TIME_W'(res_lcount_q);
			end
			default: begin
				div_dividend = DIV_W'(res_dtotal_q);
				div_divisor  = TIME_W'(res_dcount_q);
			end
		endcase
	end

	wts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET_US;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			job_q          <= JOB_LOAD;
			report_valid_q <= 1'b0;
			open_q         <= '0;
			loop_total_q   <= '0;
			loop_peak_q    <= '0;
			loop_tally_q   <= '0;
			det_total_q    <= '0;
			det_floor_q    <= '0;
			det_peak_q     <= '0;
			det_tally_q    <= '0;
		end else begin
			if (load_report) begin
				report_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				report_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= s_axis_tuser ? S_DET : S_DUR;
					end
				end
				S_DET: begin
					if (bsamples_q != '0) begin
						det_total_q <= det_total_q + bsum_q;
						if (det_tally_q == '0 || bmin_q < det_floor_q) begin
							det_floor_q <= bmin_q;
						end
						if (bmax_q > det_peak_q) begin
							det_peak_q <= bmax_q;
						end
						det_tally_q <= det_tally_q + bsamples_q;
					end
					state_q <= S_IDLE;
				end
				S_DUR: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					loop_total_q <= loop_total_q + TIME_W'(dur_q);
					if (dur_q > loop_peak_q) begin
						loop_peak_q <= dur_q;
					end
					loop_tally_q <= loop_tally_q + WORD_W'(1);
					state_q      <= S_CHK;
				end
				S_CHK: begin
					if (open_q == '0) begin
						open_q  <= end_q;
						state_q <= S_IDLE;
					end else if (close) begin
						open_q       <= end_q;
						loop_total_q <= '0;
						loop_peak_q  <= '0;
						loop_tally_q <= '0;
						det_total_q  <= '0;
						det_floor_q  <= '0;
						det_peak_q   <= '0;
						det_tally_q  <= '0;
						state_q      <= S_MUL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					job_q   <= JOB_LOAD;
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_stat.done) begin
						case (job_q)
							JOB_LOAD: begin
								job_q   <= JOB_LAVG;
								state_q <= S_DSTART;
							end
							JOB_LAVG: begin
								job_q   <= JOB_DAVG;
								state_q <= S_DSTART;
							end
							default: begin
								job_q   <= JOB_LOAD;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (load_report) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			start_q    <= s_axis_tdata[63:0];
			end_q      <= s_axis_tdata[127:64];
			bsum_q     <= s_axis_tdata[191:128];
			bsamples_q <= s_axis_tdata[223:192];
			bmin_q     <= s_axis_tdata[255:224];
			bmax_q     <= s_axis_tdata[287:256];
		end
		if (state_q == S_DUR) begin
			dur_q <= span[TIME_W] ? '0 : sat32(DIV_W'(span[TIME_W-1:0]));
		end
		if (state_q == S_ACC) begin
			elapsed_q <= {1'b0, end_q} - {1'b0, open_q};
		end
		if (state_q == S_CHK) begin
			snap_total_q <= loop_total_q;
			res_win_q    <= sat32(DIV_W'(elapsed_q[TIME_W-1:0]));
			res_lcount_q <= loop_tally_q;
			res_lpeak_q  <= loop_peak_q;
			res_dcount_q <= det_tally_q;
			res_dtotal_q <= det_total_q;
			res_dfloor_q <= det_floor_q;
			res_dpeak_q  <= det_peak_q;
		end
		if (state_q == S_MUL) begin
			// times 25, the remaining factor 1024 is a shift
			prod25_q <= {snap_total_q, 5'b0} - {2'b0, snap_total_q, 3'b0}
				+ PROD25_W'(snap_total_q);
			load_full_q <= snap_total_q >= elapsed_q[TIME_W-1:0];
		end
		if (state_q == S_DWAIT && div_stat.done) begin
			case (job_q)
				JOB_LOAD: begin
					res_load_q <= load_full_q ? LOAD_FULL_Q8 : div_quot[LOAD_W-1:0];
				end
				JOB_LAVG: begin
					res_lavg_q <= (res_lcount_q == '0) ? '0 : sat32(div_quot);
				end
				default: begin
					res_davg_q <= (res_dcount_q == '0) ? '0 : sat32(div_quot);
				end
			endcase
		end
		if (load_report) begin
			report_q <= {1'b0, res_dpeak_q, res_dfloor_q, res_davg_q, res_dtotal_q,
				res_dcount_q, res_lpeak_q, res_lavg_q, res_lcount_q, res_load_q, res_win_q};
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = report_valid_q;
	assign m_axis_tdata  = report_q;

`ifndef SYNTHESIS
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("report changed while waiting");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && open_q != '0 && close) |=>
		(loop_tally_q == '0 && det_tally_q == '0 && loop_total_q == '0))
		else $error("accumulators not cleared on window close");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |-> !div_stat.busy) else $error("divider started while busy");
	a_load_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[LOAD_W+WORD_W-1:WORD_W] <= LOAD_FULL_Q8)
		else $error("load share above full");
`endif

endmodule

// ===== bench/tb_windowed_timing_statistics.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_timing_statistics
// drives loop events and detection batches through the timing monitor and
// checks every window report against a cycle-free model of the statistics,
// under random idling on both streams and several window intervals
// ----------------------------------------------------------------------------
module tb_windowed_timing_statistics import wts_pkg::*;;

	localparam bit OP_LOOP  = 1'b0;
	localparam bit OP_BATCH = 1'b1;
	localparam int HOLD_CYCLES = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 300;

	// request fields, first field in the lowest bits
	typedef struct packed {
		logic [31:0] max_us;
		logic [31:0] min_us;
		logic [31:0] samples;
		logic [63:0] sum_us;
		logic [63:0] end_us;
		logic [63:0] launch_us;
	} timing_req_t;

	typedef struct packed {
		logic        pad;
		logic [31:0] detect_peak;
		logic [31:0] detect_floor;
		logic [31:0] detect_avg;
		logic [63:0] detect_total;
		logic [31:0] detect_count;
		logic [31:0] loop_peak;
		logic [31:0] loop_avg;
		logic [31:0] loop_count;
		logic [14:0] load_q8;
		logic [31:0] window_len;
	} window_report_t;

	class window_report_board;
		logic [31:0] interval_us;
		logic [63:0] open_time;
		logic [63:0] loop_total;
		logic [31:0] loop_peak;
		logic [31:0] loop_tally;
		logic [63:0] detect_total;
		logic [31:0] detect_floor;
		logic [31:0] detect_peak;
		logic [31:0] detect_tally;
		window_report_t due_reports[$];
		int mismatches;

		function new();
			interval_us = INTERVAL_RESET_US;
			open_time = '0;
			mismatches = 0;
			clear_window();
		endfunction

		function void clear_window();
			loop_total = '0;
			loop_peak = '0;
			loop_tally = '0;
			detect_total = '0;
			detect_floor = '0;
			detect_peak = '0;
			detect_tally = '0;
		endfunction

		function logic [31:0] clip_word(logic [63:0] v);
			return (v[63:32] != '0) ? WORD_MAX : v[31:0];
		endfunction

		function void absorb_request(bit op, timing_req_t r);
			logic [63:0] elapsed;
			logic [31:0] dur;
			logic [127:0] scaled;
			window_report_t rep;
			if (op == OP_BATCH) begin
				if (r.samples != '0) begin
					detect_total += r.sum_us;
					if (detect_tally == '0 || r.min_us < detect_floor) begin
						detect_floor = r.min_us;
					end
					if (r.max_us > detect_peak) begin
						detect_peak = r.max_us;
					end
					detect_tally += r.samples;
				end
				return;
			end
			dur = (r.end_us > r.launch_us) ? clip_word(r.end_us - r.launch_us) : '0;
			loop_total += {32'd0, dur};
			if (dur > loop_peak) begin
				loop_peak = dur;
			end
			loop_tally += 32'd1;
			if (open_time == '0) begin
				open_time = r.end_us;
				return;
			end
			if (r.end_us <= open_time) begin
				return;
			end
			elapsed = r.end_us - open_time;
			if (elapsed < {32'd0, interval_us}) begin
				return;
			end
			rep = '0;
			rep.window_len = clip_word(elapsed);
			if (loop_total >= elapsed) begin
				rep.load_q8 = LOAD_FULL_Q8;
			end else begin
				scaled = ({64'd0, loop_total} * {113'd0, LOAD_FULL_Q8}) / {64'd0, elapsed};
				rep.load_q8 = scaled[14:0];
			end
			rep.loop_count = loop_tally;
			rep.loop_avg = (loop_tally != '0) ? clip_word(loop_total / {32'd0, loop_tally}) : '0;
			rep.loop_peak = loop_peak;
			rep.detect_count = detect_tally;
			rep.detect_total = detect_total;
			rep.detect_avg = (detect_tally != '0) ?
				clip_word(detect_total / {32'd0, detect_tally}) : '0;
			rep.detect_floor = detect_floor;
			rep.detect_peak = detect_peak;
			due_reports.push_back(rep);
			open_time = r.end_us;
			clear_window();
		endfunction

		function void match_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				if (mismatches < 10) begin
					$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				end
				mismatches++;
			end
		endfunction

		function void check_report(logic [335:0] bus);
			window_report_t got;
			window_report_t want;
			got = bus;
			if (due_reports.size() == 0) begin
				if (mismatches < 10) begin
					$display("%0t: report with none pending: %h", $time, bus);
				end
				mismatches++;
				return;
			end
			want = due_reports.pop_front();
			match_field("window_length_us", 64'(want.window_len), 64'(got.window_len));
			match_field("load_percent_q8", 64'(want.load_q8), 64'(got.load_q8));
			match_field("loop_count", 64'(want.loop_count), 64'(got.loop_count));
			match_field("loop_mean_us", 64'(want.loop_avg), 64'(got.loop_avg));
			match_field("loop_peak_us", 64'(want.loop_peak), 64'(got.loop_peak));
			match_field("detect_count", 64'(want.detect_count), 64'(got.detect_count));
			match_field("detect_total_us", want.detect_total, got.detect_total);
			match_field("detect_average_us", 64'(want.detect_avg), 64'(got.detect_avg));
			match_field("detect_floor_us", 64'(want.detect_floor), 64'(got.detect_floor));
			match_field("detect_peak_us", 64'(want.detect_peak), 64'(got.detect_peak));
		endfunction

		function int pending();
			return due_reports.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic         s_axis_tuser;
	logic [287:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [335:0] m_axis_tdata;

	window_report_board board = new();
	logic [63:0] now_us;
	bit hold_req;

	windowed_timing_statistics dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_report(m_axis_tdata);
		end
	end

	// report side
	initial begin
		int n;
		m_axis_tready = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end
			n = idle_gap();
			if (n > 0) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	task automatic send_request(input bit op, input timing_req_t r);
		int gap;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = r;
		do @(posedge clk); while (!s_axis_tready);
		board.absorb_request(op, r);
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// batch fields carry noise on a loop event
	task automatic send_loop(input logic [63:0] launch_us, input logic [63:0] end_us);
		timing_req_t r;
		r.launch_us = launch_us;
		r.end_us = end_us;
		r.sum_us = rand64();
		r.samples = $urandom;
		r.min_us = $urandom;
		r.max_us = $urandom;
		send_request(OP_LOOP, r);
	endtask

	task automatic send_batch(input logic [63:0] sum_us, input logic [31:0] samples,
			input logic [31:0] min_us, input logic [31:0] max_us);
		timing_req_t r;
		r.launch_us = rand64();
		r.end_us = rand64();
		r.sum_us = sum_us;
		r.samples = samples;
		r.min_us = min_us;
		r.max_us = max_us;
		send_request(OP_BATCH, r);
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_interval(input logic [31:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		board.interval_us = v;
	endtask

	task automatic run_phase(input int count, input logic [63:0] step);
		logic [63:0] s;
		logic [63:0] e;
		logic [63:0] sum;
		logic [31:0] n;
		logic [31:0] lo;
		logic [31:0] hi;
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				case ($urandom_range(0, 9))
					0: n = '0;
					1: n = $urandom;
					default: n = $urandom_range(1, 64);
				endcase
				lo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
				hi = ($urandom_range(0, 9) == 0) ? $urandom : lo + $urandom_range(0, 5000);
				sum = ($urandom_range(0, 4) == 0) ? rand64() :
					{32'd0, n} * {32'd0, lo} + {32'd0, $urandom_range(0, 5000)};
				send_batch(sum, n, lo, hi);
			end else if (r < 85) begin
				s = now_us + rand64() % (step / 4 + 1);
				e = s + rand64() % (step + 1);
				now_us = e;
				send_loop(s, e);
			end else if (r < 91) begin
				// very long loop, duration clipped to a word
				e = now_us + rand64() % (step + 1);
				s = (e > 64'h2_0000_0000) ? e - 64'h1_0000_0000 - {32'd0, $urandom} : '0;
				now_us = e;
				send_loop(s, e);
			end else if (r < 96) begin
				// stale end time, arbitrary start
				e = rand64() % (now_us + 1);
				send_loop(rand64(), e);
			end else begin
				// start after end
				e = now_us + rand64() % (step + 1);
				s = e + 64'd1 + {32'd0, $urandom};
				now_us = e;
				send_loop(s, e);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = OP_LOOP;
		s_axis_tdata = '0;
		hold_req = 1'b0;
		now_us = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// window still closed, ignored and wrapping batches
		send_loop(64'd0, 64'd0);
		send_batch('1, 32'd0, 32'd0, '1);
		send_batch('1, 32'd1, '1, '1);
		send_batch(64'd5, '1, 32'd0, 32'd0);
		send_batch(64'd100, 32'd2, 32'd40, 32'd60);
		// open, time going back, equal time, exact interval
		send_loop(64'd100, 64'd1000);
		send_loop(64'd600, 64'd500);
		send_loop(64'd0, 64'd1000);
		send_loop(64'd1000, 64'd1_000_999);
		send_loop(64'd1_000_999, 64'd1_001_000);
		send_batch(rand64(), $urandom, $urandom, $urandom);
		// clipped duration and window length
		send_loop(64'd1, 64'h2_0000_0000);
		now_us = 64'h2_0000_0000;

		settle();
		write_interval('0);
		send_loop(now_us, now_us + 64'd1);
		now_us = now_us + 64'd1;
		send_loop(now_us - 64'd5, now_us);

		settle();
		write_interval(32'd1);
		send_batch(64'd7, 32'd3, 32'd1, 32'd4);
		send_loop(now_us, now_us + 64'd1);
		now_us = now_us + 64'd1;

		settle();
		write_interval('1);
		send_loop(now_us, now_us + 64'hFFFF_FFFE);
		now_us = now_us + 64'hFFFF_FFFE;
		send_loop(now_us, now_us + 64'd1);
		now_us = now_us + 64'd1;
		send_loop(now_us, now_us + 64'h1_0000_0000);
		now_us = now_us + 64'h1_0000_0000;

		settle();
		hold_req = 1'b1;
		write_interval('0);
		run_phase(150, 64'd50);

		settle();
		write_interval(32'd1);
		run_phase(100, 64'd20);

		settle();
		write_interval(32'd1000);
		run_phase(150, 64'd300);

		settle();
		write_interval('1);
		run_phase(120, 64'h4000_0000);

		settle();
		write_interval(32'd5000);
		run_phase(150, 64'd2000);

		settle();
		write_interval(INTERVAL_RESET_US);
		now_us = 64'hD000_0000_0000_0000 | (rand64() >> 8);
		run_phase(180, 64'd200000);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("tb_windowed_timing_statistics: done, clean");
		end else begin
			$display("tb_windowed_timing_statistics: done, errors");
		end
		$finish;
	end

	initial begin
		#80_000_000;
		$display("tb_windowed_timing_statistics: done, errors");
		$finish;
	end

endmodule

// ===== windowed_timing_statistics.f =====
rtl/wts_pkg.sv
rtl/wts_div.sv
rtl/windowed_timing_statistics.sv
bench/tb_windowed_timing_statistics.sv
